FILE: rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types, codes and helpers for the text encoding and line-ending
// sniffer.
// ----------------------------------------------------------------------------
package tes_pkg;

  // Field widths of one input item and one result item.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned EncW   = 3;
  localparam int unsigned MarkW  = 2;
  localparam int unsigned StyleW = 2;
  localparam int unsigned ResW   = EncW + MarkW + StyleW;
  localparam int unsigned OutDataW = ((ResW + 7) / 8) * 8;

  // Encoding codes.
  localparam logic [EncW-1:0] ENC_ANSI     = 3'd0;
  localparam logic [EncW-1:0] ENC_UTF8_BOM = 3'd1;
  localparam logic [EncW-1:0] ENC_UTF8     = 3'd2;
  localparam logic [EncW-1:0] ENC_UTF16_BE = 3'd3;
  localparam logic [EncW-1:0] ENC_UTF16_LE = 3'd4;

  // Byte-order mark lengths.
  localparam logic [MarkW-1:0] MARK_NONE  = 2'd0;
  localparam logic [MarkW-1:0] MARK_UTF16 = 2'd2;
  localparam logic [MarkW-1:0] MARK_UTF8  = 2'd3;

  // Line-ending style codes.
  localparam logic [StyleW-1:0] EOL_WINDOWS = 2'd0;
  localparam logic [StyleW-1:0] EOL_UNIX    = 2'd1;
  localparam logic [StyleW-1:0] EOL_MAC     = 2'd2;

  // Byte values of interest.
  localparam logic [ByteW-1:0] BYTE_EF = 8'hEF;
  localparam logic [ByteW-1:0] BYTE_BB = 8'hBB;
  localparam logic [ByteW-1:0] BYTE_BF = 8'hBF;
  localparam logic [ByteW-1:0] BYTE_FE = 8'hFE;
  localparam logic [ByteW-1:0] BYTE_FF = 8'hFF;
  localparam logic [ByteW-1:0] BYTE_CR = 8'h0D;
  localparam logic [ByteW-1:0] BYTE_LF = 8'h0A;

  // One result item.
  typedef struct packed {
    logic [StyleW-1:0] line_style;
    logic [MarkW-1:0]  mark_length;
    logic [EncW-1:0]   encoding;
  } tes_result_t;

  // Number of leading one bits of a byte, 0 to 8.
  function automatic logic [3:0] lead_ones(input logic [ByteW-1:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = ByteW - 1; i >= 0; i--) begin
      run = run & b[i];
      n   = n + {3'd0, run};
    end
    return n;
  endfunction

endpackage

FILE: rtl/tes_scan.sv
// ----------------------------------------------------------------------------
// tes_scan
// Per-byte scan state: byte-order mark capture, UTF-8 well-formedness
// tracking and line-ending detection, with the result of the final byte.
// ----------------------------------------------------------------------------
module tes_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [tes_pkg::ByteW-1:0]   byte_i,
  input  logic                        last_i,
  output tes_pkg::tes_result_t        result_o
);
  import tes_pkg::*;

  logic [1:0]       seen_q, seen_d;
  logic [ByteW-1:0] lb0_q, lb0_d;
  logic [ByteW-1:0] lb1_q, lb1_d;
  logic             bom8_q, bom8_d;
  logic [2:0]       cont_q, cont_d;
  logic             broken_q, broken_d;
  logic             high_q, high_d;
  logic             dec_q, dec_d;
  logic [StyleW-1:0] kind_q, kind_d;
  logic             wait_q, wait_d;
  logic [1:0]       dist_q, dist_d;

  logic [3:0] ones;
  logic       utf16_be;
  logic       utf16_le;
  logic [1:0] dist_dec;

  // Mark capture over the first three bytes.
  always_comb begin
    lb0_d  = lb0_q;
    lb1_d  = lb1_q;
    bom8_d = bom8_q;
    case (seen_q)
      2'd0: lb0_d = byte_i;
      2'd1: lb1_d = byte_i;
      2'd2: bom8_d = (lb0_q == BYTE_EF) && (lb1_q == BYTE_BB) && (byte_i == BYTE_BF);
      default: ;
    endcase
    seen_d = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
  end

  assign utf16_be = (seen_d >= 2'd2) && (lb0_d == BYTE_FE) && (lb1_d == BYTE_FF);
  assign utf16_le = (seen_d >= 2'd2) && (lb0_d == BYTE_FF) && (lb1_d == BYTE_FE);

  // UTF-8 structure: a lead byte owes its continuation bytes.
  assign ones = lead_ones(byte_i);
  always_comb begin
    high_d   = high_q | byte_i[7];
    broken_d = broken_q;
    cont_d   = cont_q;
    if (!broken_q) begin
      if (cont_q == 3'd0) begin
        if (byte_i[7]) begin
          if (ones == 4'd1) begin
            broken_d = 1'b1;
          end else begin
            cont_d = 3'(ones - 4'd1);
          end
        end
      end else if (byte_i[7:6] != 2'b10) begin
        broken_d = 1'b1;
      end else begin
        cont_d = cont_q - 3'd1;
      end
    end
  end

  // Line ending: the first CR or LF settles it.
  assign dist_dec = dist_q - 2'd1;
  always_comb begin
    dec_d  = dec_q;
    kind_d = kind_q;
    wait_d = wait_q;
    dist_d = dist_q;
    if (!dec_q) begin
      if (wait_q) begin
        dist_d = dist_dec;
        if (dist_dec == 2'd0) begin
          kind_d = (byte_i == BYTE_LF) ? EOL_WINDOWS : EOL_MAC;
          dec_d  = 1'b1;
          wait_d = 1'b0;
        end
      end else if (byte_i == BYTE_CR) begin
        wait_d = 1'b1;
        dist_d = (utf16_be || utf16_le) ? 2'd2 : 2'd1;
      end else if (byte_i == BYTE_LF) begin
        kind_d = EOL_UNIX;
        dec_d  = 1'b1;
      end
    end
  end

  // Result of the stream as it stands after this byte.
  always_comb begin
    if (utf16_be) begin
      result_o.encoding    = ENC_UTF16_BE;
      result_o.mark_length = MARK_UTF16;
    end else if (utf16_le) begin
      result_o.encoding    = ENC_UTF16_LE;
      result_o.mark_length = MARK_UTF16;
    end else if (bom8_d) begin
      result_o.encoding    = ENC_UTF8_BOM;
      result_o.mark_length = MARK_UTF8;
    end else if (!broken_d && (cont_d == 3'd0) && high_d) begin
      result_o.encoding    = ENC_UTF8;
      result_o.mark_length = MARK_NONE;
    end else begin
      result_o.encoding    = ENC_ANSI;
      result_o.mark_length = MARK_NONE;
    end
    if (dec_d) begin
      result_o.line_style = kind_d;
    end else if (wait_d) begin
      result_o.line_style = EOL_MAC;
    end else begin
      result_o.line_style = EOL_WINDOWS;
    end
  end

  // State update; the final byte clears everything for the next stream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 2'd0;
      lb0_q    <= '0;
      lb1_q    <= '0;
      bom8_q   <= 1'b0;
      cont_q   <= 3'd0;
      broken_q <= 1'b0;
      high_q   <= 1'b0;
      dec_q    <= 1'b0;
      kind_q   <= EOL_WINDOWS;
      wait_q   <= 1'b0;
      dist_q   <= 2'd0;
    end else if (step_i) begin
      if (last_i) begin
        seen_q   <= 2'd0;
        lb0_q    <= '0;
        lb1_q    <= '0;
        bom8_q   <= 1'b0;
        cont_q   <= 3'd0;
        broken_q <= 1'b0;
        high_q   <= 1'b0;
        dec_q    <= 1'b0;
        kind_q   <= EOL_WINDOWS;
        wait_q   <= 1'b0;
        dist_q   <= 2'd0;
      end else begin
        seen_q   <= seen_d;
        lb0_q    <= lb0_d;
        lb1_q    <= lb1_d;
        bom8_q   <= bom8_d;
        cont_q   <= cont_d;
        broken_q <= broken_d;
        high_q   <= high_d;
        dec_q    <= dec_d;
        kind_q   <= kind_d;
        wait_q   <= wait_d;
        dist_q   <= dist_d;
      end
    end
  end

`ifndef SYNTHESIS
  // A final byte leaves a clean state behind.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> (seen_q == 2'd0) && !dec_q && !wait_q && !broken_q)
    else $error("scan state not cleared after final byte");

  // A pending CR and a settled style never coexist.
  a_eol_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dec_q && wait_q))
    else $error("CR pending after line style settled");

  // A pending CR always has a look-ahead distance left.
  a_cr_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q |-> (dist_q != 2'd0))
    else $error("pending CR with zero distance");
`endif

endmodule

FILE: rtl/tes_out.sv
// ----------------------------------------------------------------------------
// tes_out
// Result register of the sniffer: holds one result item until the
// downstream side takes it.
// ----------------------------------------------------------------------------
module tes_out (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  tes_pkg::tes_result_t           result_i,
  output logic                           free_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tes_pkg::OutDataW-1:0]   m_axis_tdata
);
  import tes_pkg::*;

  logic        valid_q;
  tes_result_t data_q;

  // The slot is free when empty or when its item leaves this cycle.
  assign free_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      data_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{(OutDataW - ResW){1'b0}}, data_q};

`ifndef SYNTHESIS
  // A load is only requested into a slot that can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result loaded into an occupied slot");

  // A result that was taken is gone next cycle unless a new one came.
  a_taken_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && m_axis_tready && !load_i |=> !valid_q)
    else $error("result repeated after hand-off");

  // A load always shows up as a valid result.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not presented");
`endif

endmodule

FILE: rtl/text_encoding_and_eol_sniffer.sv
// ----------------------------------------------------------------------------
// text_encoding_and_eol_sniffer
// Scans a text buffer byte by byte and reports its encoding, byte-order
// mark length and line-ending style after the last byte.
// ----------------------------------------------------------------------------
// One byte is taken per cycle, with tlast on the final byte of a buffer.
// A byte is held in the input register, and its scan step updates the
// state at the edge where it moves on; for the final byte the result
// is loaded into the output register at that same edge, from which it
// is presented on the master side. The sustained rate is one byte per
// cycle, set by the single-step update of the scan state; the input
// side only waits while a finished result is held back by the downstream
// side and another final byte is due. All scan state is cleared after
// each buffer. Result tdata carries encoding (0 ansi, 1 UTF-8 with mark,
// 2 UTF-8, 3 UTF-16 BE, 4 UTF-16 LE), mark length and line style
// (0 CRLF, 1 LF, 2 CR).
module text_encoding_and_eol_sniffer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tes_pkg::ByteW-1:0]     s_axis_tdata,  // [7:0] text_byte
  input  logic                          s_axis_tlast,  // final_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] encoding, [4:3] mark_length, [6:5] line_style, [7] zero
  output logic [tes_pkg::OutDataW-1:0]  m_axis_tdata
);
  import tes_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             advance;
  logic             out_free;
  tes_result_t      result;

  // The registered byte moves on unless its result has nowhere to go.
  assign advance       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Scan state and result logic.
  tes_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .result_o (result)
  );

  // Result register toward the master side.
  tes_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance && in_last_q),
    .result_i      (result),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
